// ===== sv/rspm_pkg.sv =====
// ----------------------------------------------------------------------------
// rspm_pkg
// Types and constants shared by the subimage pixel map blocks.
// ----------------------------------------------------------------------------
package rspm_pkg;

    localparam int DISPLAY_WIDTH_PX_DEF   = 2048;
    localparam int DISPLAY_HEIGHT_PX_DEF  = 1024;
    localparam int SUBIMAGE_WIDTH_PX_DEF  = 16;
    localparam int SUBIMAGE_HEIGHT_PX_DEF = 16;

    localparam int CFG_W  = 24;
    localparam int CFG_AW = 3;

    // depth of the queue between front and back end, power of two
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_AW-1:0] {
        REG_CAMERA_X  = 3'd0,
        REG_CAMERA_Y  = 3'd1,
        REG_CAMERA_Z  = 3'd2,
        REG_THICKNESS = 3'd3,
        REG_INDEX     = 3'd4,
        REG_WIDTH_MM  = 3'd5,
        REG_HEIGHT_MM = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [6:0] subimage_col;
        logic [5:0] subimage_row;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [23:0] camera_x;
        logic signed [23:0] camera_y;
        logic [23:0]        camera_z;
        logic [23:0]        thickness;
        logic [18:0]        index;
        logic [23:0]        width_mm;
        logic [23:0]        height_mm;
    } t_cfg;

    // classified work item handed from the front end to the back end
    typedef struct packed {
        logic [6:0]  col;
        logic [5:0]  row;
        logic        x_neg;
        logic        y_neg;
        logic [63:0] num_x;
        logic [63:0] num_y;
        logic [63:0] q;
    } t_work;

endpackage

// ===== sv/rspm_front.sv =====
// ----------------------------------------------------------------------------
// rspm_front
// Forms the ray coordinates from the subimage index and the radicand.
// Four register stages; takes an item each cycle while i_adv is high.
// ----------------------------------------------------------------------------
module rspm_front #(
    parameter int DISPLAY_WIDTH_PX   = 2048,
    parameter int DISPLAY_HEIGHT_PX  = 1024,
    parameter int SUBIMAGE_WIDTH_PX  = 16,
    parameter int SUBIMAGE_HEIGHT_PX = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  rspm_pkg::t_in_item i_item,
    input  rspm_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    output rspm_pkg::t_work   o_work
);
    import rspm_pkg::*;

    // stage 1: centers and x, y
    logic        r_v1;
    logic [6:0]  r_col1;
    logic [5:0]  r_row1;
    logic signed [40:0] r_x1, r_y1;
    // stage 2: squares
    logic        r_v2;
    logic [6:0]  r_col2;
    logic [5:0]  r_row2;
    logic        r_xn2, r_yn2;
    logic [31:0] r_ax2, r_ay2;
    logic [63:0] r_sx2, r_sy2;
    logic [35:0] r_nn2, r_z22;
    // stage 3: products
    logic        r_v3;
    logic [6:0]  r_col3;
    logic [5:0]  r_row3;
    logic        r_xn3, r_yn3;
    logic [63:0] r_nx3, r_ny3, r_q3;

    logic signed [40:0] n_x, n_y;
    logic signed [31:0] dx, dy;
    logic [23:0] zz;
    logic [18:0] nc;
    logic [31:0] mx, my;
    logic [64:0] s2sum;
    logic [63:0] s2;

    // offset of the subimage center from the display middle, Q16.16
    function automatic logic signed [31:0] x_off(input int col);
        longint c2;
        longint v;
        c2 = 2 * ((longint'(SUBIMAGE_WIDTH_PX) * (2 * col + 1)) / 2);
        v  = ((c2 - DISPLAY_WIDTH_PX) * 65536) / DISPLAY_HEIGHT_PX;
        return 32'(v);
    endfunction

    function automatic logic signed [31:0] y_off(input int row);
        longint c2;
        longint v;
        c2 = 2 * ((longint'(SUBIMAGE_HEIGHT_PX) * (2 * row + 1)) / 2);
        v  = ((DISPLAY_HEIGHT_PX - c2) * 65536) / DISPLAY_HEIGHT_PX;
        return 32'(v);
    endfunction

    logic signed [31:0] dx_tab [128];
    logic signed [31:0] dy_tab [64];

    for (genvar c = 0; c < 128; c++) begin : g_dx
        localparam logic signed [31:0] OFF = x_off(c);
        assign dx_tab[c] = OFF;
    end

    for (genvar r = 0; r < 64; r++) begin : g_dy
        localparam logic signed [31:0] OFF = y_off(r);
        assign dy_tab[r] = OFF;
    end

    always_comb begin
        dx  = dx_tab[i_item.subimage_col];
        dy  = dy_tab[i_item.subimage_row];
        n_x = 41'(i_cfg.camera_x) - 41'(dx);
        n_y = 41'(i_cfg.camera_y) - 41'(dy);
    end

    assign zz = (i_cfg.camera_z == '0) ? 24'd1 : i_cfg.camera_z;
    assign nc = (i_cfg.index < 19'd65536) ? 19'd65536 :
                (i_cfg.index > 19'd262144) ? 19'd262144 : i_cfg.index;
    assign mx = r_x1[40] ? 32'(-r_x1) : 32'(r_x1);
    assign my = r_y1[40] ? 32'(-r_y1) : 32'(r_y1);
    assign s2sum = 65'(r_sx2) + 65'(r_sy2);
    assign s2 = 64'(s2sum[64:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_col1 <= i_item.subimage_col;
            r_row1 <= i_item.subimage_row;
            r_x1 <= n_x;
            r_y1 <= n_y;

            r_col2 <= r_col1;
            r_row2 <= r_row1;
            r_xn2 <= r_x1[40];
            r_yn2 <= r_y1[40];
            r_ax2 <= mx;
            r_ay2 <= my;
            r_sx2 <= 64'(mx) * 64'(mx);
            r_sy2 <= 64'(my) * 64'(my);
            r_nn2 <= 36'((38'(nc) * 38'(nc)) >> 16);
            r_z22 <= 36'((48'(zz) * 48'(zz)) >> 16);

            r_col3 <= r_col2;
            r_row3 <= r_row2;
            r_xn3 <= r_xn2;
            r_yn3 <= r_yn2;
            r_nx3 <= 64'(SUBIMAGE_WIDTH_PX) * 64'(i_cfg.thickness) * 64'(r_ax2);
            r_ny3 <= 64'(SUBIMAGE_HEIGHT_PX) * 64'(i_cfg.thickness) * 64'(r_ay2);
            r_q3  <= 64'(r_nn2) * 64'(r_z22) + 64'(r_nn2 - 36'd65536) * s2;

            o_work.col   <= r_col3;
            o_work.row   <= r_row3;
            o_work.x_neg <= r_xn3;
            o_work.y_neg <= r_yn3;
            o_work.num_x <= r_nx3;
            o_work.num_y <= r_ny3;
            o_work.q     <= r_q3;
        end
    end

endmodule

// ===== sv/rspm_back.sv =====
// ----------------------------------------------------------------------------
// rspm_back
// Pipelined square root, two pipelined dividers and the output clamps.
// ----------------------------------------------------------------------------
module rspm_back #(
    parameter int SUBIMAGE_WIDTH_PX  = 16,
    parameter int SUBIMAGE_HEIGHT_PX = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  rspm_pkg::t_work   i_work,
    input  rspm_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    output rspm_pkg::t_out_item o_item
);
    import rspm_pkg::*;

    localparam int SQ_ST = 32;  // one result bit per stage
    localparam int DV_ST = 64;  // one quotient bit per stage
    // input register, sqrt, divisor stages, divider, output register
    localparam int NST   = 1 + SQ_ST + 3 + DV_ST + 1;

    logic [NST-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (i_adv) r_v <= {r_v[NST-2:0], i_valid};
    end
    assign o_valid = r_v[NST-1];

    // square root: restoring, one bit per stage
    logic [63:0] r_sq_rem [SQ_ST+1];
    logic [31:0] r_sq_res [SQ_ST+1];
    t_work       r_sq_w   [SQ_ST+1];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sq_rem[0] <= i_work.q;
            r_sq_res[0] <= '0;
            r_sq_w[0]   <= i_work;
        end
    end

    for (genvar k = 0; k < SQ_ST; k++) begin : g_sq
        localparam int B = SQ_ST - 1 - k;
        logic [65:0] trial;
        logic [31:0] cand;
        assign cand  = r_sq_res[k] | (32'd1 << B);
        assign trial = 66'(cand) * 66'(cand);
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_sq_rem[k+1] <= r_sq_rem[k];
                r_sq_res[k+1] <= (trial <= 66'(r_sq_rem[k])) ? cand : r_sq_res[k];
                r_sq_w[k+1]   <= r_sq_w[k];
            end
        end
    end

    // divisor products
    logic [55:0] r_px, r_py;
    t_work       r_d_w;
    logic [63:0] r_dx, r_dy;
    t_work       r_e_w;
    logic [23:0] wmm, hmm;
    assign wmm = (i_cfg.width_mm  == '0) ? 24'd1 : i_cfg.width_mm;
    assign hmm = (i_cfg.height_mm == '0) ? 24'd1 : i_cfg.height_mm;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_px  <= 56'(r_sq_res[SQ_ST]) * 56'(wmm);
            r_py  <= 56'(r_sq_res[SQ_ST]) * 56'(hmm);
            r_d_w <= r_sq_w[SQ_ST];
            r_dx  <= (r_px[55:16] == '0) ? 64'd1 : 64'(r_px[55:16]);
            r_dy  <= (r_py[55:16] == '0) ? 64'd1 : 64'(r_py[55:16]);
            r_e_w <= r_d_w;
        end
    end

    // restoring dividers, one quotient bit per stage
    logic [63:0] r_rx [DV_ST+1], r_ry [DV_ST+1];
    logic [63:0] r_nx [DV_ST+1], r_ny [DV_ST+1];
    logic [63:0] r_gx [DV_ST+1], r_gy [DV_ST+1];
    t_work       r_dw [DV_ST+1];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rx[0] <= '0;
            r_ry[0] <= '0;
            r_nx[0] <= r_e_w.num_x;
            r_ny[0] <= r_e_w.num_y;
            r_gx[0] <= r_dx;
            r_gy[0] <= r_dy;
            r_dw[0] <= r_e_w;
        end
    end

    for (genvar k = 0; k < DV_ST; k++) begin : g_dv
        logic [64:0] shx, shy;
        assign shx = {r_rx[k], r_nx[k][63]};
        assign shy = {r_ry[k], r_ny[k][63]};
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (shx >= 65'(r_gx[k])) begin
                    r_rx[k+1] <= 64'(shx - 65'(r_gx[k]));
                    r_nx[k+1] <= {r_nx[k][62:0], 1'b1};
                end else begin
                    r_rx[k+1] <= shx[63:0];
                    r_nx[k+1] <= {r_nx[k][62:0], 1'b0};
                end
                if (shy >= 65'(r_gy[k])) begin
                    r_ry[k+1] <= 64'(shy - 65'(r_gy[k]));
                    r_ny[k+1] <= {r_ny[k][62:0], 1'b1};
                end else begin
                    r_ry[k+1] <= shy[63:0];
                    r_ny[k+1] <= {r_ny[k][62:0], 1'b0};
                end
                r_gx[k+1] <= r_gx[k];
                r_gy[k+1] <= r_gy[k];
                r_dw[k+1] <= r_dw[k];
            end
        end
    end

    // final sums and clamps
    always_ff @(posedge i_clk) begin
        logic signed [65:0] tx, ty, ax, ay, px, py;
        logic sat;
        t_work w;
        if (i_adv) begin
            w  = r_dw[DV_ST];
            tx = 66'(SUBIMAGE_WIDTH_PX << 15) +
                 (w.x_neg ? -$signed({2'b0, r_nx[DV_ST]}) : $signed({2'b0, r_nx[DV_ST]}));
            ty = 66'(SUBIMAGE_HEIGHT_PX << 15) -
                 (w.y_neg ? -$signed({2'b0, r_ny[DV_ST]}) : $signed({2'b0, r_ny[DV_ST]}));
            ax = $signed(66'(SUBIMAGE_WIDTH_PX * int'(w.col))  << 16) + tx;
            ay = $signed(66'(SUBIMAGE_HEIGHT_PX * int'(w.row)) << 16) + ty;
            // truncate toward zero
            px = ax[65] ? -((-ax) >>> 16) : (ax >>> 16);
            py = ay[65] ? -((-ay) >>> 16) : (ay >>> 16);
            sat = 1'b0;
            if (tx < -66'sd2147483648) begin o_item.target_x <= 32'h8000_0000; sat = 1'b1; end
            else if (tx > 66'sd2147483647) begin o_item.target_x <= 32'h7fff_ffff; sat = 1'b1; end
            else o_item.target_x <= tx[31:0];
            if (ty < -66'sd2147483648) begin o_item.target_y <= 32'h8000_0000; sat = 1'b1; end
            else if (ty > 66'sd2147483647) begin o_item.target_y <= 32'h7fff_ffff; sat = 1'b1; end
            else o_item.target_y <= ty[31:0];
            if (px < -66'sd32768) begin o_item.pixel_x <= 16'h8000; sat = 1'b1; end
            else if (px > 66'sd32767) begin o_item.pixel_x <= 16'h7fff; sat = 1'b1; end
            else o_item.pixel_x <= px[15:0];
            if (py < -66'sd32768) begin o_item.pixel_y <= 16'h8000; sat = 1'b1; end
            else if (py > 66'sd32767) begin o_item.pixel_y <= 16'h7fff; sat = 1'b1; end
            else o_item.pixel_y <= py[15:0];
            o_item.saturated <= sat;
        end
    end

endmodule

// ===== sv/rspm_fifo.sv =====
// ----------------------------------------------------------------------------
// rspm_fifo
// Short work queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rspm_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rspm_pkg::t_work     i_item,
    input  logic                i_pop,
    output logic                o_empty,
    output logic                o_full,
    output rspm_pkg::t_work     o_item
);
    import rspm_pkg::*;
    localparam int AW = $clog2(DEPTH);

    t_work         r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          wr, rd;

    assign wr = i_push && !o_full;
    assign rd = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_item  = r_mem[r_rp];

endmodule

// ===== sv/refraction_subimage_pixel_map.sv =====
// ----------------------------------------------------------------------------
// refraction_subimage_pixel_map
// Maps a subimage index to its refracted target center and absolute pixel.
// path: front end, queue, sqrt, divisor stages, dividers, output register
// throughput: one transaction per cycle while results are popped as they appear,
// set by the fully pipelined sqrt and dividers
// a result left waiting holds the back end; the queue fills and then full rises
// reset: synchronous active low; registers return to defaults, pipeline and queue empty
// ----------------------------------------------------------------------------
module refraction_subimage_pixel_map #(
    parameter int DISPLAY_WIDTH_PX   = rspm_pkg::DISPLAY_WIDTH_PX_DEF,
    parameter int DISPLAY_HEIGHT_PX  = rspm_pkg::DISPLAY_HEIGHT_PX_DEF,
    parameter int SUBIMAGE_WIDTH_PX  = rspm_pkg::SUBIMAGE_WIDTH_PX_DEF,
    parameter int SUBIMAGE_HEIGHT_PX = rspm_pkg::SUBIMAGE_HEIGHT_PX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  rspm_pkg::t_in_item            i_item,
    output logic                          empty,
    input  logic                          pop,
    output rspm_pkg::t_out_item           o_item,
    input  logic                          i_cfg_we,
    input  logic [rspm_pkg::CFG_AW-1:0]   i_cfg_idx,
    input  logic [rspm_pkg::CFG_W-1:0]    i_cfg_data
);
    import rspm_pkg::*;

    t_cfg r_cfg;
    logic fv, bv;
    t_work fw, qw;
    logic f_adv, b_adv;
    logic q_push, q_pop, q_empty, q_full;
    logic acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.camera_x  <= '0;
            r_cfg.camera_y  <= '0;
            r_cfg.camera_z  <= 24'd655360;
            r_cfg.thickness <= 24'd65536;
            r_cfg.index     <= 19'd98304;
            r_cfg.width_mm  <= 24'd65536;
            r_cfg.height_mm <= 24'd65536;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CAMERA_X:  r_cfg.camera_x  <= i_cfg_data;
                REG_CAMERA_Y:  r_cfg.camera_y  <= i_cfg_data;
                REG_CAMERA_Z:  r_cfg.camera_z  <= i_cfg_data;
                REG_THICKNESS: r_cfg.thickness <= i_cfg_data;
                REG_INDEX:     r_cfg.index     <= i_cfg_data[18:0];
                REG_WIDTH_MM:  r_cfg.width_mm  <= i_cfg_data;
                REG_HEIGHT_MM: r_cfg.height_mm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front end holds only when its last stage cannot move into the queue
    assign f_adv  = !(fv && q_full);
    assign full   = !f_adv;
    assign acc    = push && !full;
    assign q_push = fv && !q_full;

    // back end holds while the oldest result waits to be popped
    assign b_adv  = !(bv && !pop);
    assign q_pop  = !q_empty && b_adv;
    assign empty  = !bv;

    rspm_front #(
        .DISPLAY_WIDTH_PX  (DISPLAY_WIDTH_PX),
        .DISPLAY_HEIGHT_PX (DISPLAY_HEIGHT_PX),
        .SUBIMAGE_WIDTH_PX (SUBIMAGE_WIDTH_PX),
        .SUBIMAGE_HEIGHT_PX(SUBIMAGE_HEIGHT_PX)
    ) u_front (
        .i_clk, .i_rst_n, .i_adv(f_adv), .i_valid(acc), .i_item,
        .i_cfg(r_cfg), .o_valid(fv), .o_work(fw)
    );

    rspm_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk, .i_rst_n, .i_push(q_push), .i_item(fw), .i_pop(q_pop),
        .o_empty(q_empty), .o_full(q_full), .o_item(qw)
    );

    rspm_back #(
        .SUBIMAGE_WIDTH_PX (SUBIMAGE_WIDTH_PX),
        .SUBIMAGE_HEIGHT_PX(SUBIMAGE_HEIGHT_PX)
    ) u_back (
        .i_clk, .i_rst_n, .i_adv(b_adv), .i_valid(!q_empty), .i_work(qw),
        .i_cfg(r_cfg), .o_valid(bv), .o_item(o_item)
    );

endmodule
